/* rtl/wabc_pkg.sv */
// ----------------------------------------------------------------------------
// Wear-aware block chooser package
// Shared opcodes, register indexes, widths and state encoding.
// ----------------------------------------------------------------------------
package wabc_pkg;

   localparam int unsigned CountWidth = 32;
   localparam int unsigned CfgWidth   = 11;

   typedef enum logic [1:0] {
      OP_CHOOSE = 2'd0,
      OP_ERASE  = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [CfgWidth-1:0] {
      REG_BLOCK_COUNT = 11'd0,
      REG_POOL_LIMIT  = 11'd1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_ERASE_RD,
      ST_ERASE_WR,
      ST_MINMAX,
      ST_BIT_SCAN,
      ST_BIT_DECIDE,
      ST_CAND_SCAN,
      ST_DONE
   } state_type;

endpackage

/* rtl/wabc_addr_mod.sv */
// ----------------------------------------------------------------------------
// Address modulo unit
// Restoring remainder of a 64-bit address by the block count, one bit a cycle.
// ----------------------------------------------------------------------------
module wabc_addr_mod import wabc_pkg::*; #(
   parameter int unsigned IdxWidth = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         dividend,
   input  logic [IdxWidth:0]   divisor,
   output logic                done,
   output logic [IdxWidth-1:0] remainder
);

   logic [63:0]       shift_ff, shift_in;
   logic [IdxWidth:0] rem_ff, rem_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [IdxWidth+1:0] trial;

   // One restoring step per cycle.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff, shift_ff[63]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = 7'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[62:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = (IdxWidth+1)'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[IdxWidth:0];
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done      = busy_ff && (cnt_ff == 7'd64) ? 1'b0 : (!busy_ff && cnt_ff == 7'd64);
   assign remainder = rem_ff[IdxWidth-1:0];

endmodule

/* rtl/wear_aware_block_chooser_core.sv */
// ----------------------------------------------------------------------------
// Wear-aware block chooser core
// Erase counters in one memory, median by bitwise rank search, scan selection.
// ----------------------------------------------------------------------------
// Usage: the requester presents req_valid with the payload; a transaction is
// taken when req_valid is high and req_stall is low. Results leave on the
// rsp_ channel, one per request, held while rsp_stall is high. Settings are
// written through csr_ only while the block is idle: a rule for the user, not enforced by the block.
// Operation: choose first finds the address remainder, then makes 32 passes
// over the memory to find the median bit by bit, then a min and max pass and
// a candidate scan. The single memory read port serialises these passes; one
// request is worked at a time.
// Reset: a clearing pass writes zero to every one of NUM_BLOCKS entries, one
// a cycle, during which no request is taken.
// A stalled result stays in the output register; the next request is taken
// once that result is handed over.
// ----------------------------------------------------------------------------
module wear_aware_block_chooser_core import wabc_pkg::*; #(
   parameter int unsigned NUM_BLOCKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_address,
   input  logic        req_hot,
   input  logic [9:0]  req_target_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_chosen_block,
   output logic        rsp_fell_back,
   output logic [31:0] rsp_new_count,
   output logic [31:0] rsp_min_wear,
   output logic [31:0] rsp_max_wear,
   input  logic        csr_write,
   input  logic [CfgWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0] csr_data
);

   localparam int unsigned AW = $clog2(NUM_BLOCKS);
   localparam int unsigned NW = AW + 1;

   // Erase count memory.
   logic [CountWidth-1:0] mem [NUM_BLOCKS];
   logic [CountWidth-1:0] rd_data_ff;
   logic [AW-1:0]         rd_addr, wr_addr;
   logic                  wr_en;
   logic [CountWidth-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Registers.
   logic [CfgWidth-1:0] bc_ff, pl_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff <= CfgWidth'(1024);
         pl_ff <= CfgWidth'(8);
      end else if (csr_write) begin
         if (csr_index == REG_BLOCK_COUNT) bc_ff <= csr_data;
         else if (csr_index == REG_POOL_LIMIT) pl_ff <= csr_data;
      end
   end

   logic [NW-1:0] n_use;
   always_comb begin
      if (bc_ff == '0) n_use = NW'(1);
      else if ({{(32-CfgWidth){1'b0}}, bc_ff} > 32'(NUM_BLOCKS)) n_use = NW'(NUM_BLOCKS);
      else n_use = NW'(bc_ff);
   end

   // Address remainder unit.
   logic          mod_start, mod_done;
   logic [AW-1:0] mod_rem;
   wabc_addr_mod #(.IdxWidth(AW)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(req_address),
      .divisor(n_use), .done(mod_done), .remainder(mod_rem)
   );

   state_type st_ff, st_in;
   logic [1:0]  op_ff, op_in;
   logic        hot_ff, hot_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   logic [AW-1:0] start_ff, start_in;
   logic [NW-1:0] cnt_ff, cnt_in;     // issue counter
   logic [NW-1:0] rcv_ff, rcv_in;     // data counter
   logic          rv_ff, rv_in;       // read data valid
   logic [AW-1:0] ridx_ff, ridx_in;   // index of data in rd_data_ff
   logic [CountWidth-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0] loi_ff, loi_in, hii_ff, hii_in;
   logic [CountWidth-1:0] pre_ff, pre_in; // median prefix
   logic [4:0]    bit_ff, bit_in;
   logic [NW-1:0] rank_ff, rank_in;   // rank still sought
   logic [NW-1:0] zc_ff, zc_in;       // count with bit zero under prefix
   logic [CfgWidth-1:0] ex_ff, ex_in;
   logic          fnd_ff, fnd_in;
   logic [AW-1:0] best_ff, best_in;
   logic [CountWidth-1:0] bestc_ff, bestc_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic          ov_ff, ov_in;
   logic [9:0]    o_ch_ff, o_ch_in;
   logic          o_fb_ff, o_fb_in;
   logic [31:0]   o_nc_ff, o_nc_in, o_lo_ff, o_lo_in, o_hi_ff, o_hi_in;

   logic [CountWidth-1:0] msk, c;
   logic [AW:0] sum_idx;
   logic take;

   // Sequencer.
   always_comb begin
      st_in = st_ff; op_in = op_ff; hot_in = hot_ff; tgt_in = tgt_ff;
      start_in = start_ff; cnt_in = cnt_ff; rcv_in = rcv_ff;
      rv_in = 1'b0; ridx_in = ridx_ff;
      lo_in = lo_ff; hi_in = hi_ff; loi_in = loi_ff; hii_in = hii_ff;
      pre_in = pre_ff; bit_in = bit_ff; rank_in = rank_ff; zc_in = zc_ff;
      ex_in = ex_ff; fnd_in = fnd_ff; best_in = best_ff; bestc_in = bestc_ff;
      clr_in = clr_ff;
      ov_in = ov_ff; o_ch_in = o_ch_ff; o_fb_in = o_fb_ff;
      o_nc_in = o_nc_ff; o_lo_in = o_lo_ff; o_hi_in = o_hi_ff;
      rd_addr = '0; wr_en = 1'b0; wr_addr = clr_ff; wr_data = '0;
      mod_start = 1'b0;
      req_stall = 1'b1;
      c = rd_data_ff;
      msk = ~(32'hFFFF_FFFF >> bit_ff) ;
      sum_idx = '0;
      take = 1'b0;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;

      case (st_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_BLOCKS - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = ov_ff;
            if (req_valid && !ov_ff) begin
               op_in = req_opcode; hot_in = req_hot;
               tgt_in = AW'(req_target_block);
               o_ch_in = '0; o_fb_in = 1'b0; o_nc_in = '0; o_lo_in = '0; o_hi_in = '0;
               cnt_in = '0; rcv_in = '0;
               case (opcode_type'(req_opcode))
                  OP_CHOOSE: begin
                     mod_start = 1'b1;
                     st_in = ST_MOD;
                  end
                  OP_ERASE: begin
                     if ({{(16-10){1'b0}}, req_target_block} < 16'(n_use)) st_in = ST_ERASE_RD;
                     else st_in = ST_DONE;
                  end
                  OP_QUERY: st_in = ST_MINMAX;
                  default: st_in = ST_DONE;
               endcase
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               start_in = mod_rem;
               pre_in = '0; bit_in = '0; rank_in = n_use >> 1;
               zc_in = '0; st_in = ST_BIT_SCAN;
            end
         end
         ST_ERASE_RD: begin
            rd_addr = tgt_ff;
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(1)) st_in = ST_ERASE_WR;
         end
         ST_ERASE_WR: begin
            wr_en = 1'b1; wr_addr = tgt_ff;
            wr_data = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 32'd1;
            o_nc_in = wr_data;
            st_in = ST_DONE;
         end
         ST_MINMAX: begin
            // Streamed walk; each result arrives in the cycle after its read.
            rd_addr = cnt_ff[AW-1:0];
            if (cnt_ff < n_use) begin
               cnt_in = cnt_ff + NW'(1);
               rv_in = 1'b1; ridx_in = cnt_ff[AW-1:0];
            end
            if (rv_ff) begin
               rcv_in = rcv_ff + NW'(1);
               if (rcv_ff == '0 || c < lo_ff) begin lo_in = c; loi_in = ridx_ff; end
               if (rcv_ff == '0 || c > hi_ff) begin hi_in = c; hii_in = ridx_ff; end
               if (rcv_ff + NW'(1) == n_use) begin
                  o_lo_in = (rcv_ff == '0 || c < lo_ff) ? c : lo_ff;
                  o_hi_in = (rcv_ff == '0 || c > hi_ff) ? c : hi_ff;
                  st_in = (op_ff == OP_CHOOSE) ? ST_CAND_SCAN : ST_DONE;
                  cnt_in = '0; rcv_in = '0;
                  ex_in = '0; fnd_in = 1'b0;
               end
            end
         end
         ST_BIT_SCAN: begin
            // Count entries matching the prefix with the current bit clear.
            rd_addr = cnt_ff[AW-1:0];
            if (cnt_ff < n_use) begin
               cnt_in = cnt_ff + NW'(1);
               rv_in = 1'b1;
            end
            if (rv_ff) begin
               rcv_in = rcv_ff + NW'(1);
               if (((c & msk) == pre_ff) && !c[5'd31 - bit_ff]) zc_in = zc_ff + NW'(1);
               if (rcv_ff + NW'(1) == n_use) st_in = ST_BIT_DECIDE;
            end
         end
         ST_BIT_DECIDE: begin
            if (rank_ff >= zc_ff) begin
               rank_in = rank_ff - zc_ff;
               pre_in = pre_ff | (32'h8000_0000 >> bit_ff);
            end
            zc_in = '0; cnt_in = '0; rcv_in = '0;
            bit_in = bit_ff + 5'd1;
            // After the last bit, find min and max, then scan candidates.
            st_in = (bit_ff == 5'd31) ? ST_MINMAX : ST_BIT_SCAN;
         end
         ST_CAND_SCAN: begin
            sum_idx = {1'b0, start_ff} + (AW+1)'(cnt_ff);
            if (sum_idx >= (AW+1)'(n_use)) sum_idx = sum_idx - (AW+1)'(n_use);
            rd_addr = sum_idx[AW-1:0];
            if (cnt_ff < n_use) begin
               cnt_in = cnt_ff + NW'(1);
               rv_in = 1'b1; ridx_in = sum_idx[AW-1:0];
            end
            if (rv_ff) begin
               rcv_in = rcv_ff + NW'(1);
               take = (hot_ff ? (c <= pre_ff) : (c > pre_ff)) && (ex_ff < pl_ff);
               if (take) begin
                  ex_in = ex_ff + CfgWidth'(1);
                  if (!fnd_ff || c < bestc_ff) begin
                     best_in = ridx_ff; bestc_in = c; fnd_in = 1'b1;
                  end
               end
               if (rcv_ff + NW'(1) == n_use) begin
                  if (take && (!fnd_ff || c < bestc_ff)) begin
                     o_ch_in = 10'(ridx_ff); o_fb_in = 1'b0;
                  end else if (fnd_ff) begin
                     o_ch_in = 10'(best_ff); o_fb_in = 1'b0;
                  end else begin
                     o_ch_in = 10'(hot_ff ? loi_ff : hii_ff); o_fb_in = 1'b1;
                  end
                  o_lo_in = '0; o_hi_in = '0;
                  st_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            ov_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; hot_ff <= hot_in; tgt_ff <= tgt_in; start_ff <= start_in;
      cnt_ff <= cnt_in; rcv_ff <= rcv_in; ridx_ff <= ridx_in;
      lo_ff <= lo_in; hi_ff <= hi_in; loi_ff <= loi_in; hii_ff <= hii_in;
      pre_ff <= pre_in; bit_ff <= bit_in; rank_ff <= rank_in; zc_ff <= zc_in;
      ex_ff <= ex_in; fnd_ff <= fnd_in; best_ff <= best_in; bestc_ff <= bestc_in;
      o_ch_ff <= o_ch_in; o_fb_ff <= o_fb_in; o_nc_ff <= o_nc_in;
      o_lo_ff <= o_lo_in; o_hi_ff <= o_hi_in;
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         rv_ff  <= rv_in;
         ov_ff  <= ov_in;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_chosen_block = o_ch_ff;
   assign rsp_fell_back    = o_fb_ff;
   assign rsp_new_count    = o_nc_ff;
   assign rsp_min_wear     = o_lo_ff;
   assign rsp_max_wear     = o_hi_ff;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Wear-aware block chooser core testbench
// Sends choose, erase, query and unused-opcode transactions through the
// request channel. Each transaction is scored against an internal model of
// the erase count store under several block count and pool limit settings,
// with random idle cycles and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench import wabc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Blocks = 1024;

   typedef struct {
      opcode_type  op;
      logic [63:0] address;
      logic        hot;
      logic [9:0]  target;
   } wear_req_type;

   typedef struct {
      logic [9:0]  chosen;
      logic        fell_back;
      logic [31:0] new_count;
      logic [31:0] min_wear;
      logic [31:0] max_wear;
   } wear_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [63:0] req_address = '0;
   logic        req_hot = 1'b0;
   logic [9:0]  req_target_block = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_chosen_block;
   logic        rsp_fell_back;
   logic [31:0] rsp_new_count;
   logic [31:0] rsp_min_wear;
   logic [31:0] rsp_max_wear;
   logic        csr_write = 1'b0;
   logic [CfgWidth-1:0] csr_index = '0;
   logic [CfgWidth-1:0] csr_data = '0;

   // Model state: erase counts and register copies.
   logic [31:0]         wear_counts [Blocks];
   logic [CfgWidth-1:0] model_block_count;
   logic [CfgWidth-1:0] model_pool_limit;

   wear_req_type pending_reqs [$];
   wear_rsp_type expected_rsps [$];
   int errors = 0;
   int sent_count = 0;
   int checked_count = 0;
   int choose_count = 0;
   bit no_idle = 1'b0;

   wear_aware_block_chooser_core #(.NUM_BLOCKS(Blocks)) i_dut (.*);

   always #6 clock = ~clock;

   function automatic int unsigned blocks_in_use();
      if (model_block_count == 0) return 1;
      if (model_block_count > Blocks) return Blocks;
      return model_block_count;
   endfunction

   // Computes the result of one transaction and applies its effect on the store.
   function automatic wear_rsp_type predict_wear(wear_req_type r);
      wear_rsp_type res;
      int unsigned n, start, taken, idx;
      logic [31:0] med, c;
      logic [31:0] ranked [$];
      bit found, accept;
      res = '{default: '0};
      n = blocks_in_use();
      case (r.op)
         OP_CHOOSE: begin
            for (int i = 0; i < n; i++) ranked = {ranked, wear_counts[i]};
            ranked.sort();
            med = ranked[n / 2];
            start = 32'(r.address % 64'(n));
            taken = 0;
            found = 1'b0;
            for (int off = 0; off < n && taken < model_pool_limit; off++) begin
               idx = (start + off) % n;
               c = wear_counts[idx];
               accept = r.hot ? (c <= med) : (c > med);
               if (accept) begin
                  taken++;
                  if (!found || c < wear_counts[res.chosen]) begin
                     res.chosen = 10'(idx);
                     found = 1'b1;
                  end
               end
            end
            // No candidate: first global minimum for hot, maximum for cold.
            if (!found) begin
               res.chosen = '0;
               for (int i = 1; i < n; i++) begin
                  if (r.hot ? (wear_counts[i] < wear_counts[res.chosen])
                            : (wear_counts[i] > wear_counts[res.chosen]))
                     res.chosen = 10'(i);
               end
               res.fell_back = 1'b1;
            end
         end
         OP_ERASE: begin
            if (r.target < n) begin
               if (wear_counts[r.target] != 32'hFFFF_FFFF)
                  wear_counts[r.target] = wear_counts[r.target] + 32'd1;
               res.new_count = wear_counts[r.target];
            end
         end
         OP_QUERY: begin
            res.min_wear = wear_counts[0];
            res.max_wear = wear_counts[0];
            for (int i = 1; i < n; i++) begin
               if (wear_counts[i] < res.min_wear) res.min_wear = wear_counts[i];
               if (wear_counts[i] > res.max_wear) res.max_wear = wear_counts[i];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Request driver: holds each transaction until it is taken.
   wear_req_type cur_req;
   int req_gap = 0;
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && !req_stall) begin
         expected_rsps = {expected_rsps, predict_wear(cur_req)};
         sent_count++;
         if (cur_req.op == OP_CHOOSE) choose_count++;
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap == 0 && pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_opcode <= cur_req.op;
            req_address <= cur_req.address;
            req_hot <= cur_req.hot;
            req_target_block <= cur_req.target;
         end else begin
            req_valid <= 1'b0;
            req_gap <= gap;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            cur_req = pending_reqs.pop_front();
            req_opcode <= cur_req.op;
            req_address <= cur_req.address;
            req_hot <= cur_req.hot;
            req_target_block <= cur_req.target;
            req_valid <= 1'b1;
         end
      end
   end

   // Long receiver hold, counted here once the stimulus asks for it.
   event hold_start;
   bit   hold_on = 1'b0;
   always begin
      @(hold_start);
      hold_on <= 1'b1;
      repeat (2000) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Result monitor: random stalls, the long hold, field checks.
   int stall_left = 0;
   always @(posedge clock) begin
      wear_rsp_type exp_rsp;
      int next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         next_stall = stall_left;
         if (rsp_valid && !rsp_stall) begin
            checked_count++;
            if (expected_rsps.size() == 0) begin
               $error("result transaction with nothing expected");
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_chosen_block !== exp_rsp.chosen) begin
                  $error("chosen_block: expected %0d, actual %0d", exp_rsp.chosen,
                         rsp_chosen_block);
                  errors++;
               end
               if (rsp_fell_back !== exp_rsp.fell_back) begin
                  $error("fell_back: expected %0d, actual %0d", exp_rsp.fell_back,
                         rsp_fell_back);
                  errors++;
               end
               if (rsp_new_count !== exp_rsp.new_count) begin
                  $error("new_count: expected %0d, actual %0d", exp_rsp.new_count,
                         rsp_new_count);
                  errors++;
               end
               if (rsp_min_wear !== exp_rsp.min_wear) begin
                  $error("min_wear: expected %0d, actual %0d", exp_rsp.min_wear,
                         rsp_min_wear);
                  errors++;
               end
               if (rsp_max_wear !== exp_rsp.max_wear) begin
                  $error("max_wear: expected %0d, actual %0d", exp_rsp.max_wear,
                         rsp_max_wear);
                  errors++;
               end
            end
            next_stall = no_idle ? 0 : $urandom_range(0, 5);
         end else if (next_stall > 0) begin
            next_stall--;
         end
         stall_left <= next_stall;
         rsp_stall <= (next_stall != 0) || hold_on;
      end
   end

   task automatic send(opcode_type op, logic [63:0] addr, logic hot, logic [9:0] tgt);
      wear_req_type r;
      r.op = op;
      r.address = addr;
      r.hot = hot;
      r.target = tgt;
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CfgWidth-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == REG_BLOCK_COUNT) model_block_count = value;
      else model_pool_limit = value;
   endtask

   // Half erases, mostly on blocks in use so counts spread; also chooses, queries and unused opcodes.
   task automatic random_phase(int items);
      int unsigned pick, n;
      n = blocks_in_use();
      for (int k = 0; k < items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            send(OP_ERASE, {$urandom, $urandom}, 1'($urandom),
                 ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, n)));
         else if (pick < 85)
            send(OP_CHOOSE, {$urandom, $urandom}, 1'($urandom), 10'($urandom));
         else if (pick < 95)
            send(OP_QUERY, {$urandom, $urandom}, 1'($urandom), 10'($urandom));
         else
            send(OP_NONE, {$urandom, $urandom}, 1'($urandom), 10'($urandom));
      end
   endtask

   initial begin
      int unsigned phase_counts [6] = '{7, 16, 2, 12, 31, 9};
      int unsigned phase_pools  [6] = '{3, 1024, 1, 0, 2047, 5};
      for (int i = 0; i < Blocks; i++) wear_counts[i] = '0;
      model_block_count = 11'd1024;
      model_pool_limit = 11'd8;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // Let the clearing pass finish before any register write.
      repeat (Blocks + 32) @(posedge clock);

      // Directed: reset settings, extreme fields, every opcode.
      send(OP_QUERY, '0, 1'b0, '0);
      send(OP_ERASE, '0, 1'b0, 10'd0);
      send(OP_ERASE, '1, 1'b1, 10'd1023);
      send(OP_ERASE, '0, 1'b0, 10'd1023);
      send(OP_QUERY, '1, 1'b1, '1);
      send(OP_CHOOSE, '1, 1'b1, '1);
      send(OP_CHOOSE, '0, 1'b0, '0);
      send(OP_NONE, '1, 1'b1, '1);
      wait_idle();

      // One block in use: register value zero.
      write_reg(REG_BLOCK_COUNT, 11'd0);
      send(OP_CHOOSE, 64'hDEAD_BEEF_0123_4567, 1'b1, '0);
      send(OP_CHOOSE, '1, 1'b0, '0);
      send(OP_ERASE, '0, 1'b0, 10'd0);
      send(OP_ERASE, '0, 1'b0, 10'd1);
      send(OP_QUERY, '0, 1'b0, '0);
      wait_idle();

      // Block count above the store depth.
      write_reg(REG_BLOCK_COUNT, 11'd2047);
      send(OP_QUERY, '0, 1'b0, '0);
      send(OP_ERASE, '0, 1'b0, 10'd1023);
      send(OP_ERASE, '0, 1'b0, 10'd512);
      send(OP_QUERY, '0, 1'b0, '0);
      wait_idle();

      // Zero pool limit forces the fallback both ways.
      write_reg(REG_BLOCK_COUNT, 11'd5);
      write_reg(REG_POOL_LIMIT, 11'd0);
      send(OP_ERASE, '0, 1'b0, 10'd2);
      send(OP_ERASE, '0, 1'b0, 10'd4);
      send(OP_ERASE, '0, 1'b0, 10'd5);
      send(OP_CHOOSE, 64'd3, 1'b1, '0);
      send(OP_CHOOSE, 64'd3, 1'b0, '0);
      wait_idle();

      // Random phases under several settings.
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_BLOCK_COUNT, CfgWidth'(phase_counts[p]));
         write_reg(REG_POOL_LIMIT, CfgWidth'(phase_pools[p]));
         no_idle = (p == 2);
         random_phase(p == 5 ? 10 : 18);
         if (p == 1) begin
            // The sender pauses until every result is back.
            wait_idle();
            random_phase(6);
         end
         if (p == 3) begin
            // Long receiver hold while the sender keeps offering.
            -> hold_start;
            for (int k = 0; k < 8; k++) send(OP_ERASE, '0, 1'b0, 10'($urandom_range(0, 11)));
         end
         wait_idle();
      end
      no_idle = 1'b0;

      // Extra settle time, then the verdict.
      repeat (50) @(posedge clock);
      if (expected_rsps.size() > 0) begin
         $error("%0d expected results never arrived", expected_rsps.size());
         errors++;
      end
      $display("Sent %0d transactions (%0d chooses), checked %0d results,", sent_count,
               choose_count, checked_count);
      $display("over ten block count and pool limit settings.");
      if (errors == 0) begin
         $display("wear_aware_block_chooser_core regression: pass");
      end else begin
         $display("wear_aware_block_chooser_core regression: fail");
      end
      $finish;
   end

   // Watchdog in case the block hangs.
   initial begin
      #30ms;
      $display("wear_aware_block_chooser_core regression: fail");
      $finish;
   end

endmodule
